// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the date adder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define GDAD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds on a rising clock edge outside of reset.
`define GDAD_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/core/gdad_pkg.sv =====
// ----------------------------------------------------------------------------
// gdad_pkg
// Types, constants and calendar helpers shared by the date adder modules.
// ----------------------------------------------------------------------------
package gdad_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int YMOD_W  = 9;

  localparam int DEF_DAY_COUNT_WIDTH = 20;

  // 146097 days make exactly 400 Gregorian years
  localparam int unsigned CYCLE_DAYS   = 146097;
  localparam int unsigned CYCLE_YEARS  = 400;
  localparam int unsigned YEAR_LIMIT   = 9999;
  localparam int          CYCLE_DAYS_W = $clog2(CYCLE_DAYS + 1);

  localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
  localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

  localparam logic [DAY_W-1:0] LEAP_FEB_LEN = 5'd29;

  localparam logic [DAY_W-1:0] MONTH_LEN [13] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic reduce_step;
    logic clamp;
    logic cycle_step;
    logic month_step;
    logic publish;
  } gdad_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic ymod_big;
    logic left_big;
    logic month_last;
  } gdad_status_t;

  // Leap rule on the year taken modulo 400
  function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
    is_leap = (ymod == 9'd0) ||
              ((ymod[1:0] == 2'b00) && (ymod != 9'd100) &&
               (ymod != 9'd200) && (ymod != 9'd300));
  endfunction

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] mo,
                                               input logic leap);
    if (mo > DECEMBER) begin
      days_in = '0;
    end else if (mo == FEBRUARY && leap) begin
      days_in = LEAP_FEB_LEN;
    end else begin
      days_in = MONTH_LEN[mo];
    end
  endfunction

endpackage

// ===== rtl/core/gregorian_date_add_days.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// Adds a day count to a Gregorian date, stepping whole 400-year cycles and
// then single months, and flags a result year above 9999.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Payload
//   -------  -------------------  ----------------------------------------------
//   in       in_valid / in_stall  start_year, start_month, start_day, days_to_add
//   out      out_valid/out_stall  result_year, result_month, result_day,
//                                 year_overflow
//
// Per request: load, reduce start_year by 400 until the residue is below 400, clamp
// the day, remove whole 146097-day cycles, step one month per month crossed and one
// for the last month, then publish. The month loop takes the longest.
// Reset (rst, synchronous) clears the sequencer and the result valid flag.
// A stalled result sits in the output register; the next request is taken
// meanwhile and holds at publish until the register frees up.
//
module gregorian_date_add_days #(
  parameter int DAY_COUNT_WIDTH = gdad_pkg::DEF_DAY_COUNT_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [gdad_pkg::YEAR_W-1:0]  start_year,
  input  logic [gdad_pkg::MONTH_W-1:0] start_month,
  input  logic [gdad_pkg::DAY_W-1:0]   start_day,
  input  logic [DAY_COUNT_WIDTH-1:0]  days_to_add,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gdad_pkg::YEAR_W-1:0]  result_year,
  output logic [gdad_pkg::MONTH_W-1:0] result_month,
  output logic [gdad_pkg::DAY_W-1:0]   result_day,
  output logic                        year_overflow
);
  import gdad_pkg::*;

  gdad_cmd_t    cmd;
  gdad_status_t status;

  // Sequencer: load, reduce year residue, remove whole cycles, step months,
  // hand the date to the output register.
  gdad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Datapath: working date, remaining count, year mod 400 for the leap
  // rule, and the result register that parts the two channels.
  gdad_dpath #(
    .DAY_COUNT_WIDTH (DAY_COUNT_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .start_year    (start_year),
    .start_month   (start_month),
    .start_day     (start_day),
    .days_to_add   (days_to_add),
    .result_year   (result_year),
    .result_month  (result_month),
    .result_day    (result_day),
    .year_overflow (year_overflow)
  );

endmodule

// ===== rtl/core/gdad_dpath.sv =====
// ----------------------------------------------------------------------------
// gdad_dpath
// Date registers, whole-cycle and month stepping, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gdad_dpath #(
  parameter int DAY_COUNT_WIDTH = gdad_pkg::DEF_DAY_COUNT_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  gdad_pkg::gdad_cmd_t         cmd,
  output gdad_pkg::gdad_status_t      status,
  input  logic [gdad_pkg::YEAR_W-1:0]  start_year,
  input  logic [gdad_pkg::MONTH_W-1:0] start_month,
  input  logic [gdad_pkg::DAY_W-1:0]   start_day,
  input  logic [DAY_COUNT_WIDTH-1:0]  days_to_add,
  output logic [gdad_pkg::YEAR_W-1:0]  result_year,
  output logic [gdad_pkg::MONTH_W-1:0] result_month,
  output logic [gdad_pkg::DAY_W-1:0]   result_day,
  output logic                        year_overflow
);
  import gdad_pkg::*;

  // Largest year reachable: top start year, whole cycles, one more cycle of months
  localparam longint unsigned MAX_YEAR = (64'd1 << YEAR_W) - 64'd1 +
    64'(CYCLE_YEARS) * ((64'd1 << DAY_COUNT_WIDTH) / 64'(CYCLE_DAYS)) +
    64'(CYCLE_YEARS) + 64'd1;
  localparam int YW = $clog2(MAX_YEAR + 64'd1);
  localparam int LW = (DAY_COUNT_WIDTH > CYCLE_DAYS_W) ? DAY_COUNT_WIDTH : CYCLE_DAYS_W;

  logic [YW-1:0]              yr;
  logic [YEAR_W-1:0]          ymod;
  logic [MONTH_W-1:0]         mo;
  logic [DAY_W-1:0]           dy;
  logic [DAY_COUNT_WIDTH-1:0] left;

  logic                       leap;
  logic [DAY_W-1:0]           len;
  logic [DAY_W-1:0]           rest;
  logic [DAY_COUNT_WIDTH-1:0] step_len;

  assign leap     = is_leap(ymod[YMOD_W-1:0]);
  assign len      = days_in(mo, leap);
  assign rest     = len - dy;
  assign step_len = DAY_COUNT_WIDTH'(rest) + DAY_COUNT_WIDTH'(1);

  assign status.ymod_big   = ymod >= YEAR_W'(CYCLE_YEARS);
  assign status.left_big   = LW'(left) >= LW'(CYCLE_DAYS);
  assign status.month_last = left <= DAY_COUNT_WIDTH'(rest);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      yr   <= YW'(start_year);
      ymod <= start_year;
      mo   <= (start_month == '0 || start_month > DECEMBER) ? JANUARY : start_month;
      dy   <= (start_day == '0) ? DAY_W'(1) : start_day;
      left <= days_to_add;
    end
    if (cmd.reduce_step) begin
      ymod <= ymod - YEAR_W'(CYCLE_YEARS);
    end
    if (cmd.clamp && dy > len) begin
      dy <= len;
    end
    if (cmd.cycle_step) begin
      left <= DAY_COUNT_WIDTH'(LW'(left) - LW'(CYCLE_DAYS));
      yr   <= yr + YW'(CYCLE_YEARS);
    end
    if (cmd.month_step) begin
      if (status.month_last) begin
        dy   <= dy + left[DAY_W-1:0];
        left <= '0;
      end else begin
        left <= left - step_len;
        dy   <= DAY_W'(1);
        if (mo == DECEMBER) begin
          mo   <= JANUARY;
          yr   <= yr + YW'(1);
          ymod <= (ymod == YEAR_W'(CYCLE_YEARS - 1)) ? '0 : ymod + YEAR_W'(1);
        end else begin
          mo <= mo + MONTH_W'(1);
        end
      end
    end
    if (cmd.publish) begin
      result_year   <= yr[YEAR_W-1:0];
      result_month  <= mo;
      result_day    <= dy;
      year_overflow <= yr > YW'(YEAR_LIMIT);
    end
  end

  `GDAD_ASSERT(a_month_in_range, clk, rst, cmd.month_step |-> (mo >= JANUARY && mo <= DECEMBER && dy >= DAY_W'(1) && dy <= len), "month step on an invalid date")
  `GDAD_ASSERT(a_cycles_first, clk, rst, cmd.month_step |-> !status.left_big, "month step before whole cycles removed")
  `GDAD_ASSERT(a_reduce_first, clk, rst, (cmd.cycle_step || cmd.month_step) |-> !status.ymod_big, "year residue not reduced before stepping")

endmodule

// ===== rtl/core/gdad_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdad_ctrl
// Sequencer for the date adder: phases, request handshake, result valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gdad_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  output gdad_pkg::gdad_cmd_t    cmd,
  input  gdad_pkg::gdad_status_t status
);
  import gdad_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_REDUCE  = 3'd1;
  localparam logic [2:0] S_CYCLE   = 3'd2;
  localparam logic [2:0] S_MONTH   = 3'd3;
  localparam logic [2:0] S_PUBLISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (status.ymod_big) begin
          cmd.reduce_step = 1'b1;
        end else begin
          cmd.clamp  = 1'b1;
          state_next = S_CYCLE;
        end
      end
      S_CYCLE: begin
        if (status.left_big) begin
          cmd.cycle_step = 1'b1;
        end else begin
          state_next = S_MONTH;
        end
      end
      S_MONTH: begin
        cmd.month_step = 1'b1;
        if (status.month_last) begin
          state_next = S_PUBLISH;
        end
      end
      S_PUBLISH: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `GDAD_ASSERT_NEVER(a_no_overwrite, clk, rst, cmd.publish && out_valid && out_stall, "result overwritten while stalled")
  `GDAD_ASSERT(a_publish_shows, clk, rst, cmd.publish |=> out_valid, "published result not presented")
  `GDAD_ASSERT(a_one_cmd, clk, rst, $countones(cmd) <= 1, "more than one datapath command")

endmodule

// ===== bench/gregorian_date_add_days_tb.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_add_days_tb
// Self-checking bench for the date adder. Drives start dates and day counts
// through the valid/stall request channel with random gaps and stalls,
// predicts each resulting date in the bench and compares it field by field.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_tb;

  localparam int YEAR_W  = gdad_pkg::YEAR_W;
  localparam int MONTH_W = gdad_pkg::MONTH_W;
  localparam int DAY_W   = gdad_pkg::DAY_W;
  localparam int COUNT_W = gdad_pkg::DEF_DAY_COUNT_WIDTH;

  localparam int unsigned DAYS_PER_CYCLE  = gdad_pkg::CYCLE_DAYS;
  localparam int unsigned YEARS_PER_CYCLE = gdad_pkg::CYCLE_YEARS;
  localparam int unsigned LAST_4DIGIT_YR  = gdad_pkg::YEAR_LIMIT;

  localparam logic [MONTH_W-1:0] JANUARY  = gdad_pkg::JANUARY;
  localparam logic [MONTH_W-1:0] FEBRUARY = gdad_pkg::FEBRUARY;
  localparam logic [MONTH_W-1:0] DECEMBER = gdad_pkg::DECEMBER;

  // Common-year month lengths, index 0 unused
  localparam int unsigned COMMON_MONTH_DAYS [13] = '{
    0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
  };

  localparam int RANDOM_REQS   = 100;
  localparam int MAX_WAIT      = 8;
  localparam int SETTLE_CYCLES = 100;
  // Slowest request: month steps through up to a whole 400-year cycle, plus residue
  // and cycle steps and both sides' longest waits; 122 requests of that, taken ~5x over.
  localparam int CYCLE_LIMIT   = 3_000_000;

  typedef struct {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [COUNT_W-1:0] days;
    int                 gap;          // idle cycles before this request
    bit                 drain_first;  // hold until all results are back
  } date_request_t;

  typedef struct {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               overflow;
  } date_result_t;

  logic clk;
  logic rst = 1'b1;

  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [YEAR_W-1:0]  start_year  = '0;
  logic [MONTH_W-1:0] start_month = '0;
  logic [DAY_W-1:0]   start_day   = '0;
  logic [COUNT_W-1:0] days_to_add = '0;

  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [YEAR_W-1:0]  result_year;
  logic [MONTH_W-1:0] result_month;
  logic [DAY_W-1:0]   result_day;
  logic               year_overflow;

  date_request_t date_requests [$];
  date_result_t  expected_dates [$];

  int  reqs_queued    = 0;
  int  reqs_directed  = 0;
  int  reqs_taken     = 0;
  int  results_seen   = 0;
  int  overflow_seen  = 0;
  int  mismatches     = 0;
  int  cycle_count    = 0;
  int  gap_left       = 0;
  int  stall_left     = 0;
  bit  req_accepted   = 1'b0;
  bit  resp_accepted  = 1'b0;

  gregorian_date_add_days dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .start_year   (start_year),
    .start_month  (start_month),
    .start_day    (start_day),
    .days_to_add  (days_to_add),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_year  (result_year),
    .result_month (result_month),
    .result_day   (result_day),
    .year_overflow(year_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  // Leap rule on the full-width year: every 4th, except centuries not
  // divisible by 400.
  function automatic bit leap_year(input int unsigned yr);
    return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
  endfunction

  function automatic int unsigned month_length(input int unsigned yr,
                                               input int unsigned mo);
    if (mo == FEBRUARY && leap_year(yr)) begin
      return 29;
    end
    return COMMON_MONTH_DAYS[mo];
  endfunction

  // Work out the date reached from a start date after a number of days.
  // The year is kept at full width so that leap decisions past 16383 stay
  // right; only the low bits go out on the result port.
  function automatic date_result_t advance_date(input date_request_t req);
    int unsigned  yr;
    int unsigned  mo;
    int unsigned  dy;
    int unsigned  left;
    int unsigned  len;
    date_result_t res;
    yr   = req.year;
    mo   = req.month;
    dy   = req.day;
    left = req.days;
    // Normalize a bad month to January and clamp the day into the month
    if (mo < JANUARY || mo > DECEMBER) begin
      mo = JANUARY;
    end
    len = month_length(yr, mo);
    if (dy < 1) begin
      dy = 1;
    end
    if (dy > len) begin
      dy = len;
    end
    // Whole 400-year cycles leave month and day where they are
    yr   = yr + (left / DAYS_PER_CYCLE) * YEARS_PER_CYCLE;
    left = left % DAYS_PER_CYCLE;
    // Advance month by month until the rest fits in the current month
    while (left > 0) begin
      len = month_length(yr, mo);
      if (left > len - dy) begin
        left = left - (len - dy + 1);
        dy   = 1;
        mo   = mo + 1;
        if (mo > DECEMBER) begin
          mo = JANUARY;
          yr = yr + 1;
        end
      end else begin
        dy   = dy + left;
        left = 0;
      end
    end
    res.year     = yr[YEAR_W-1:0];
    res.month    = mo[MONTH_W-1:0];
    res.day      = dy[DAY_W-1:0];
    res.overflow = (yr > LAST_4DIGIT_YR);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Queue one request. Gaps come in stretches: every third block of 16
  // requests runs back to back, the rest draw 0..MAX_WAIT idle cycles.
  task automatic add_request(input int unsigned yr, input int unsigned mo,
                             input int unsigned dy, input int unsigned n,
                             input bit drain);
    date_request_t req;
    req.year        = yr[YEAR_W-1:0];
    req.month       = mo[MONTH_W-1:0];
    req.day         = dy[DAY_W-1:0];
    req.days        = n[COUNT_W-1:0];
    req.gap         = ((reqs_queued / 16) % 3 == 0) ? 0 : $urandom_range(0, MAX_WAIT);
    req.drain_first = drain;
    date_requests.push_back(req);
    reqs_queued++;
  endtask

  function automatic int unsigned random_day_count();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 400);
      1:       return $urandom_range(0, 4000);
      // land close to a whole number of 400-year cycles
      2:       return DAYS_PER_CYCLE * $urandom_range(1, 7) - 30 + $urandom_range(0, 60);
      default: return $urandom & ((1 << COUNT_W) - 1);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: change inputs on the falling edge, hold a request until
  // the rising edge that accepts it.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_requests
    date_request_t req;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || req_accepted) begin
      if (gap_left > 0) begin
        // idle before the next request
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (date_requests.size() == 0) begin
        in_valid <= 1'b0;
      end else if (date_requests[0].drain_first && expected_dates.size() != 0) begin
        // hold off until every outstanding result has come back
        in_valid <= 1'b0;
      end else begin
        req = date_requests.pop_front();
        start_year  <= req.year;
        start_month <= req.month;
        start_day   <= req.day;
        days_to_add <= req.days;
        in_valid    <= 1'b1;
        gap_left    <= (date_requests.size() != 0) ? date_requests[0].gap : 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result stall: draw a stall length per result, spend it only while a result
  // is actually offered. Every third block of 16 results goes without stalls.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_result_stall
    int n;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (resp_accepted) begin
        n = ((results_seen / 16) % 3 == 1) ? 0 : $urandom_range(0, MAX_WAIT);
      end else begin
        n = stall_left;
      end
      out_stall  <= (n != 0);
      stall_left <= (out_valid && n != 0) ? n - 1 : n;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge, predict on accepted
  // requests, compare accepted results against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_channels
    date_request_t req;
    date_result_t  exp_date;
    req_accepted  <= 1'b0;
    resp_accepted <= 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        req.year  = start_year;
        req.month = start_month;
        req.day   = start_day;
        req.days  = days_to_add;
        expected_dates.push_back(advance_date(req));
        req_accepted <= 1'b1;
        reqs_taken++;
      end
      if (out_valid && !out_stall) begin
        resp_accepted <= 1'b1;
        results_seen++;
        if (year_overflow) begin
          overflow_seen++;
        end
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected result %0d-%0d-%0d overflow %0b", $time,
                   result_year, result_month, result_day, year_overflow);
          mismatches++;
        end else begin
          exp_date = expected_dates.pop_front();
          check_field("result_year", exp_date.year, result_year);
          check_field("result_month", exp_date.month, result_month);
          check_field("result_day", exp_date.day, result_day);
          check_field("year_overflow", exp_date.overflow, year_overflow);
        end
      end
    end
  end

  // Watchdog: stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_dates.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int unsigned yr;
    int unsigned mo;

    // Directed requests: field extremes and each corner of the calendar
    add_request(2024, 2, 29, 0, 1'b0);             // zero days, leap day kept
    add_request(0, 1, 1, 0, 1'b0);                 // lowest year
    add_request(2023, 12, 31, 1, 1'b0);            // December into January
    add_request(2024, 2, 28, 1, 1'b0);             // leap February
    add_request(2023, 2, 28, 1, 1'b0);             // common February
    add_request(1900, 2, 28, 1, 1'b0);             // century, not leap
    add_request(2000, 2, 28, 1, 1'b0);             // 400th year, leap
    add_request(2021, 0, 15, 10, 1'b0);            // month zero -> January
    add_request(2021, 13, 20, 40, 1'b0);           // month past December
    add_request(2021, 15, 31, 0, 1'b0);            // all-ones month and day
    add_request(2021, 5, 0, 0, 1'b1);              // day zero, after a drain
    add_request(2021, 2, 31, 0, 1'b0);             // day past end, clamp to 28
    add_request(2024, 2, 30, 0, 1'b0);             // day past end, clamp to 29
    add_request(2021, 4, 31, 1, 1'b0);             // clamp then step
    add_request(2000, 3, 1, DAYS_PER_CYCLE, 1'b0); // exactly one cycle
    add_request(1999, 6, 15, DAYS_PER_CYCLE - 1, 1'b0); // longest residue
    add_request(9999, 12, 31, 1, 1'b0);            // first overflow year
    add_request(10000, 3, 1, 0, 1'b0);             // start year already over
    add_request(16383, 12, 31, 1, 1'b0);           // year wraps past 14 bits
    add_request(0, 1, 1, (1 << COUNT_W) - 1, 1'b0);     // largest day count
    add_request(9999, 12, 31, (1 << COUNT_W) - 1, 1'b0);
    add_request(2400, 2, 28, 366, 1'b0);
    reqs_directed = reqs_queued;

    // Random requests: mostly valid dates, some bad months and big years
    for (int i = 0; i < RANDOM_REQS; i++) begin
      yr = ($urandom_range(0, 4) == 0) ? $urandom_range(10000, 16383)
                                       : $urandom_range(0, 9999);
      case ($urandom_range(0, 7))
        0:       mo = 0;
        1:       mo = $urandom_range(13, 15);
        default: mo = $urandom_range(1, 12);
      endcase
      add_request(yr, mo, $urandom_range(0, 31), random_day_count(),
                  (i == RANDOM_REQS / 2));
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every request to go in, every result to come out, then let
    // the block sit a while to catch any stray result.
    while (reqs_taken < reqs_queued) @(posedge clk);
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d date requests (%0d directed), checked %0d results, %0d with overflow",
             reqs_taken, reqs_directed, results_seen, overflow_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
